[hw/rtl/fckl_pkg.sv]
// ----------------------------------------------------------------------------
// fckl_pkg
// shared types and constants for the four key click / long press classifier
// ----------------------------------------------------------------------------
package fckl_pkg;

   localparam int TIMER_W     = 16;
   localparam int TOTAL_W     = 32;
   localparam int INC_W       = 4;
   localparam int KEYS        = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TIMER_W-1:0] TIMER_MAX          = '1;
   localparam logic [TIMER_W-1:0] LONG_PRESS_RESET   = 16'd2000;
   localparam logic [TIMER_W-1:0] DOUBLE_CLICK_RESET = 16'd300;

   // register indexes on the csr channel
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DOUBLE_CLICK = 8'd1;

   // item kinds
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   typedef struct packed {
      logic [TIMER_W-1:0] hold_ticks;
      logic [TIMER_W-1:0] gap_ticks;
      logic               holding;
      logic               long_fired;
      logic               window_open;
      logic [KEYS-1:0]    previous_levels;
   } fckl_state_type;

   typedef struct packed {
      logic [TIMER_W-1:0] long_press_ticks;
      logic [TIMER_W-1:0] double_click_window;
   } fckl_cfg_type;

endpackage

[hw/rtl/fckl_if.sv]
// ----------------------------------------------------------------------------
// fckl channel interfaces
// valid / ready channels for scan items, results and register writes
// ----------------------------------------------------------------------------
interface fckl_req_if;
   logic valid;
   logic ready;
   logic func;
   logic key_one_level;
   logic key_two_level;
   logic key_three_level;
   logic key_four_level;

   modport source (output valid, func, key_one_level, key_two_level,
                   key_three_level, key_four_level, input ready);
   modport sink   (input valid, func, key_one_level, key_two_level,
                   key_three_level, key_four_level, output ready);
endinterface

interface fckl_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] total_count;
   logic        awaiting_second_click;

   modport source (output valid, total_count, awaiting_second_click, input ready);
   modport sink   (input valid, total_count, awaiting_second_click, output ready);
endinterface

interface fckl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fckl_pkg::CSR_INDEX_W-1:0] index;
   logic [fckl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/fckl_step.sv]
// ----------------------------------------------------------------------------
// fckl_step
// next state and total increment for one tick or scan item
// ----------------------------------------------------------------------------
module fckl_step (
   input  fckl_pkg::fckl_state_type             state,
   input  fckl_pkg::fckl_cfg_type               cfg,
   input  logic                                 func,
   input  logic [fckl_pkg::KEYS-1:0]            levels,
   output fckl_pkg::fckl_state_type             state_next,
   output logic [fckl_pkg::INC_W-1:0]           increment
);

   always_comb begin
      fckl_pkg::fckl_state_type   s;
      logic [fckl_pkg::INC_W-1:0] inc;
      logic [fckl_pkg::KEYS-1:0]  held;
      logic [fckl_pkg::KEYS-1:0]  rise;

      s    = state;
      inc  = '0;
      held = ~levels & ~state.previous_levels;
      rise = levels & ~state.previous_levels;

      if (func == fckl_pkg::FUNC_TICK) begin
         // saturating timers
         if (s.holding && (s.hold_ticks != fckl_pkg::TIMER_MAX)) begin
            s.hold_ticks = s.hold_ticks + 1'b1;
         end
         if (s.window_open && (s.gap_ticks != fckl_pkg::TIMER_MAX)) begin
            s.gap_ticks = s.gap_ticks + 1'b1;
         end
      end else begin
         // key 1: repeat while long
         if (held[0]) begin
            s.holding = 1'b1;
            if (s.hold_ticks > cfg.long_press_ticks) inc = inc + 4'd1;
         end
         if (rise[0]) begin
            if (s.hold_ticks < cfg.long_press_ticks) inc = inc + 4'd1;
            s.hold_ticks = '0;
            s.holding    = 1'b0;
         end

         // key 2: one long event per press
         if (!s.long_fired && held[1]) begin
            s.holding = 1'b1;
            if (s.hold_ticks > cfg.long_press_ticks) begin
               inc          = inc + 4'd2;
               s.long_fired = 1'b1;
            end
         end
         if (rise[1]) begin
            if (s.hold_ticks < cfg.long_press_ticks) inc = inc + 4'd1;
            s.holding    = 1'b0;
            s.long_fired = 1'b0;
            s.hold_ticks = '0;
         end

         // key 3: single / double click
         if (!s.window_open) begin
            if (rise[2]) s.window_open = 1'b1;
         end else if (s.gap_ticks < cfg.double_click_window) begin
            if (rise[2]) begin
               inc           = inc + 4'd2;
               s.gap_ticks   = '0;
               s.window_open = 1'b0;
            end
         end else begin
            inc           = inc + 4'd1;
            s.gap_ticks   = '0;
            s.window_open = 1'b0;
         end

         // key 4: long press, then single / double click
         if (!s.long_fired && !s.window_open && held[3]) begin
            s.holding = 1'b1;
            if (s.hold_ticks > cfg.long_press_ticks) begin
               inc          = inc + 4'd3;
               s.long_fired = 1'b1;
            end
         end
         if (!s.window_open) begin
            if (rise[3]) begin
               if (s.hold_ticks < cfg.long_press_ticks) s.window_open = 1'b1;
               s.long_fired = 1'b0;
               s.holding    = 1'b0;
               s.hold_ticks = '0;
            end
         end else if (s.gap_ticks < cfg.double_click_window) begin
            if (rise[3]) begin
               inc           = inc + 4'd2;
               s.gap_ticks   = '0;
               s.window_open = 1'b0;
            end
         end else begin
            inc           = inc + 4'd1;
            s.gap_ticks   = '0;
            s.window_open = 1'b0;
         end

         s.previous_levels = levels;
      end

      state_next = s;
      increment  = inc;
   end

endmodule

[hw/rtl/four_key_click_long_classifier.sv]
// ----------------------------------------------------------------------------
// four_key_click_long_classifier
// click, double click and long press classifier for four active-low keys
// ----------------------------------------------------------------------------
//  channel   dir  payload                                     transfer when
//  req_bus   in   func, key_one..key_four_level               valid && ready
//  rsp_bus   out  total_count[31:0], awaiting_second_click    valid && ready
//  csr_bus   in   index[7:0], data[15:0]                      valid && ready
//
//  the step logic runs between the state registers and the result register,
//  so a new req transfer is taken every clock while the result register is free or draining
//  one rsp transfer per req transfer, result shown the cycle after
//  reset (synchronous, high) clears the state and loads the default registers
//  a stalled rsp holds req ready low only while the result register is full
//  and not being taken
// ----------------------------------------------------------------------------
module four_key_click_long_classifier (
   input  logic       clock,
   input  logic       reset,
   fckl_req_if.sink   req_bus,
   fckl_rsp_if.source rsp_bus,
   fckl_csr_if.sink   csr_bus
);

   // architectural state
   fckl_pkg::fckl_state_type              state_ff, state_in;
   logic [fckl_pkg::TOTAL_W-1:0]          total_ff, total_in;
   fckl_pkg::fckl_cfg_type                cfg_ff, cfg_in;
   logic                                  rsp_valid_ff, rsp_valid_in;

   fckl_pkg::fckl_state_type              step_state;
   logic [fckl_pkg::INC_W-1:0]            step_inc;
   logic [fckl_pkg::KEYS-1:0]             levels;
   logic                                  req_xfer;

   // result register is free or draining this cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // bit 0 is key 1
   assign levels = {req_bus.key_four_level, req_bus.key_three_level,
                    req_bus.key_two_level, req_bus.key_one_level};

   fckl_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .func       (req_bus.func),
      .levels     (levels),
      .state_next (step_state),
      .increment  (step_inc)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      cfg_in       = cfg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      if (req_xfer) begin
         state_in     = step_state;
         total_in     = total_ff + {{(fckl_pkg::TOTAL_W-fckl_pkg::INC_W){1'b0}}, step_inc};
         rsp_valid_in = 1'b1;
      end

      // register writes; unknown indexes fall through
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            fckl_pkg::REG_LONG_PRESS:   cfg_in.long_press_ticks    = csr_bus.data;
            fckl_pkg::REG_DOUBLE_CLICK: cfg_in.double_click_window = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hold_ticks      <= '0;
         state_ff.gap_ticks       <= '0;
         state_ff.holding         <= 1'b0;
         state_ff.long_fired      <= 1'b0;
         state_ff.window_open     <= 1'b0;
         state_ff.previous_levels <= '1;
         total_ff                 <= '0;
         cfg_ff.long_press_ticks    <= fckl_pkg::LONG_PRESS_RESET;
         cfg_ff.double_click_window <= fckl_pkg::DOUBLE_CLICK_RESET;
         rsp_valid_ff             <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result fields come straight from the state after the last item
   assign rsp_bus.valid                 = rsp_valid_ff;
   assign rsp_bus.total_count           = total_ff;
   assign rsp_bus.awaiting_second_click = state_ff.window_open;

   // every accepted item leaves a result behind
   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("req transfer without result");

   // one scan adds at most 8 to the total
   a_inc_bound: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> ((total_ff - $past(total_ff)) <= 32'd8))
      else $error("total jumped too far");

   // state moves only on a req transfer
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> ($stable(state_ff) && $stable(total_ff)))
      else $error("state changed without a req transfer");

endmodule
